// File: design/dual_set_union_intersection_macros.svh
// Assertion macros for the dual set union and intersection block.
`ifndef DUAL_SET_UNION_INTERSECTION_MACROS_SVH
`define DUAL_SET_UNION_INTERSECTION_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DSUI_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define DSUI_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define DSUI_ASSERT_NXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/dsui_pkg.sv
// Shared constants, codes, payload types and helpers of the set block.
package dsui_pkg;

   localparam int CAPACITY  = 16;
   localparam int KEY_WIDTH = 32;

   localparam int DEPTH  = 2 * CAPACITY;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int TOT_W  = $clog2(DEPTH + 1);
   localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int SIZE_W = 5;
   localparam int ELEM_W = 32;

   typedef logic [2:0] op_type;
   localparam op_type OP_INSERT = 3'd0;
   localparam op_type OP_REMOVE = 3'd1;
   localparam op_type OP_QUERY  = 3'd2;
   localparam op_type OP_UNION  = 3'd3;
   localparam op_type OP_INTER  = 3'd4;
   localparam op_type OP_CLEAR  = 3'd5;

   typedef logic [2:0] status_type;
   localparam status_type ST_OK           = 3'd0;
   localparam status_type ST_DUPLICATE    = 3'd1;
   localparam status_type ST_REMOVE_EMPTY = 3'd2;
   localparam status_type ST_NOT_PRESENT  = 3'd3;
   localparam status_type ST_FULL         = 3'd4;

   typedef struct packed {
      op_type              op;
      logic                which_set;
      logic [ELEM_W-1:0]   key;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic                is_member;
      logic [SIZE_W-1:0]   set_size;
      logic [ELEM_W-1:0]   element;
      logic                element_valid;
      logic                last;
   } rsp_type;

   function automatic logic [KEY_WIDTH-1:0] to_key(input logic [ELEM_W-1:0] k);
      logic [KEY_WIDTH+ELEM_W-1:0] e;
      e = {{KEY_WIDTH{1'b0}}, k};
      return e[KEY_WIDTH-1:0];
   endfunction

   function automatic logic [ELEM_W-1:0] to_elem(input logic [KEY_WIDTH-1:0] k);
      logic [KEY_WIDTH+ELEM_W-1:0] e;
      e = {{ELEM_W{1'b0}}, k};
      return e[ELEM_W-1:0];
   endfunction

   function automatic logic [SIZE_W-1:0] to_size(input logic [TOT_W-1:0] n);
      logic [TOT_W+SIZE_W-1:0] e;
      e = {{SIZE_W{1'b0}}, n};
      return e[SIZE_W-1:0];
   endfunction

endpackage

// File: design/dsui_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dsui_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: design/dsui_seq.sv
// Sequencer and key comparator that run every set operation over the key RAM.
module dsui_seq (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  dsui_pkg::req_type               req_payload,
   output logic                            emit_valid,
   input  logic                            emit_ready,
   output dsui_pkg::rsp_type               emit_payload,
   output logic                            ram_we,
   output logic [dsui_pkg::ADDR_W-1:0]     ram_waddr,
   output logic [dsui_pkg::KEY_WIDTH-1:0]  ram_wdata,
   output logic [dsui_pkg::ADDR_W-1:0]     ram_raddr,
   input  logic [dsui_pkg::KEY_WIDTH-1:0]  ram_rdata
);

   typedef enum logic [9:0] {
      S_IDLE     = 10'b0000000001,
      S_FIND_RD  = 10'b0000000010,
      S_FIND_CMP = 10'b0000000100,
      S_SHIFT_RD = 10'b0000001000,
      S_SHIFT_WR = 10'b0000010000,
      S_OUT_RD   = 10'b0000100000,
      S_OUT_LD   = 10'b0001000000,
      S_P2_SEL   = 10'b0010000000,
      S_P2_EMIT  = 10'b0100000000,
      S_EMIT1    = 10'b1000000000
   } state_type;

   state_type                          state_ff, state_in;
   dsui_pkg::op_type                   op_ff, op_in;
   logic                               set_ff, set_in;
   logic [dsui_pkg::KEY_WIDTH-1:0]     fkey_ff, fkey_in;
   logic [dsui_pkg::CNT_W-1:0]         i_ff, i_in;
   logic [dsui_pkg::CNT_W-1:0]         j_ff, j_in;
   logic [dsui_pkg::CNT_W-1:0]         cnt_a_ff, cnt_a_in;
   logic [dsui_pkg::CNT_W-1:0]         cnt_b_ff, cnt_b_in;
   logic [dsui_pkg::CNT_W-1:0]         hits_ff, hits_in;
   logic [dsui_pkg::CAPACITY-1:0]      flag_ff, flag_in;
   logic [dsui_pkg::TOT_W-1:0]         total_ff, total_in;
   logic [dsui_pkg::TOT_W-1:0]         emitted_ff, emitted_in;
   logic                               phase_b_ff, phase_b_in;
   dsui_pkg::status_type               status_ff, status_in;
   logic                               member_ff, member_in;
   logic [dsui_pkg::SIZE_W-1:0]        size_ff, size_in;

   logic [dsui_pkg::CNT_W-1:0]         cnt_cur, cnt_inc, cnt_dec, req_cnt;
   logic [dsui_pkg::CNT_W-1:0]         i_inc, find_n, outer_n, p2_n;
   logic                               find_set, outer_set, p2_set, p2_need;
   logic                               find_end, find_hit, is_union, is_last;
   logic [dsui_pkg::TOT_W-1:0]         total_p1, emitted_inc;

   function automatic logic [dsui_pkg::ADDR_W-1:0] slot(
      input logic s,
      input logic [dsui_pkg::CNT_W-1:0] idx
   );
      logic [dsui_pkg::ADDR_W-1:0] base;
      base = s ? dsui_pkg::ADDR_W'(dsui_pkg::CAPACITY) : '0;
      return base + dsui_pkg::ADDR_W'(idx);
   endfunction

   assign req_stall   = (state_ff != S_IDLE);
   assign is_union    = (op_ff == dsui_pkg::OP_UNION);
   assign cnt_cur     = set_ff ? cnt_b_ff : cnt_a_ff;
   assign cnt_inc     = cnt_cur + 1'b1;
   assign cnt_dec     = cnt_cur - 1'b1;
   assign req_cnt     = req_payload.which_set ? cnt_b_ff : cnt_a_ff;
   assign i_inc       = i_ff + 1'b1;
   assign find_set    = is_union ? 1'b0 : (op_ff == dsui_pkg::OP_INTER) ? 1'b1 : set_ff;
   assign find_n      = find_set ? cnt_b_ff : cnt_a_ff;
   assign outer_set   = is_union;
   assign outer_n     = outer_set ? cnt_b_ff : cnt_a_ff;
   assign p2_set      = is_union && phase_b_ff;
   assign p2_n        = p2_set ? cnt_b_ff : cnt_a_ff;
   assign p2_need     = (is_union && !phase_b_ff) ? 1'b1 : flag_ff[i_ff[dsui_pkg::IDX_W-1:0]];
   assign total_p1    = is_union ?
                        dsui_pkg::TOT_W'(cnt_a_ff) + dsui_pkg::TOT_W'(hits_ff) :
                        dsui_pkg::TOT_W'(hits_ff);
   assign emitted_inc = emitted_ff + 1'b1;
   assign is_last     = (emitted_inc == total_ff);

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      set_in     = set_ff;
      fkey_in    = fkey_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      cnt_a_in   = cnt_a_ff;
      cnt_b_in   = cnt_b_ff;
      hits_in    = hits_ff;
      flag_in    = flag_ff;
      total_in   = total_ff;
      emitted_in = emitted_ff;
      phase_b_in = phase_b_ff;
      status_in  = status_ff;
      member_in  = member_ff;
      size_in    = size_ff;
      find_end   = 1'b0;
      find_hit   = 1'b0;
      ram_we     = 1'b0;
      ram_waddr  = slot(set_ff, cnt_cur);
      ram_wdata  = fkey_ff;
      ram_raddr  = '0;
      emit_valid = 1'b0;
      emit_payload.status        = status_ff;
      emit_payload.is_member     = member_ff;
      emit_payload.set_size      = size_ff;
      emit_payload.element       = '0;
      emit_payload.element_valid = 1'b0;
      emit_payload.last          = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in      = req_payload.op;
               set_in     = req_payload.which_set;
               fkey_in    = dsui_pkg::to_key(req_payload.key);
               i_in       = '0;
               j_in       = '0;
               hits_in    = '0;
               emitted_in = '0;
               phase_b_in = 1'b0;
               member_in  = 1'b0;
               status_in  = dsui_pkg::ST_OK;
               unique case (req_payload.op) inside
                  dsui_pkg::OP_INSERT, dsui_pkg::OP_QUERY: begin
                     state_in = S_FIND_RD;
                  end
                  dsui_pkg::OP_REMOVE: begin
                     if (req_cnt == '0) begin
                        status_in = dsui_pkg::ST_REMOVE_EMPTY;
                        size_in   = '0;
                        state_in  = S_EMIT1;
                     end else begin
                        state_in = S_FIND_RD;
                     end
                  end
                  dsui_pkg::OP_CLEAR: begin
                     if (req_payload.which_set) begin
                        cnt_b_in = '0;
                     end else begin
                        cnt_a_in = '0;
                     end
                     size_in  = '0;
                     state_in = S_EMIT1;
                  end
                  dsui_pkg::OP_UNION, dsui_pkg::OP_INTER: begin
                     state_in = S_OUT_RD;
                  end
                  default: begin
                     size_in  = dsui_pkg::to_size(dsui_pkg::TOT_W'(req_cnt));
                     state_in = S_EMIT1;
                  end
               endcase
            end
         end
         S_FIND_RD: begin
            if (j_ff >= find_n) begin
               find_end = 1'b1;
            end else begin
               ram_raddr = slot(find_set, j_ff);
               state_in  = S_FIND_CMP;
            end
         end
         S_FIND_CMP: begin
            if (ram_rdata == fkey_ff) begin
               find_end = 1'b1;
               find_hit = 1'b1;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = S_FIND_RD;
            end
         end
         S_SHIFT_RD: begin
            if (i_inc < cnt_cur) begin
               ram_raddr = slot(set_ff, i_inc);
               state_in  = S_SHIFT_WR;
            end else begin
               if (set_ff) begin
                  cnt_b_in = cnt_dec;
               end else begin
                  cnt_a_in = cnt_dec;
               end
               status_in = dsui_pkg::ST_OK;
               size_in   = dsui_pkg::to_size(dsui_pkg::TOT_W'(cnt_dec));
               state_in  = S_EMIT1;
            end
         end
         S_SHIFT_WR: begin
            ram_we    = 1'b1;
            ram_waddr = slot(set_ff, i_ff);
            ram_wdata = ram_rdata;
            i_in      = i_inc;
            state_in  = S_SHIFT_RD;
         end
         S_OUT_RD: begin
            if (i_ff >= outer_n) begin
               if (total_p1 == '0) begin
                  status_in = dsui_pkg::ST_OK;
                  size_in   = '0;
                  state_in  = S_EMIT1;
               end else begin
                  total_in   = total_p1;
                  i_in       = '0;
                  phase_b_in = 1'b0;
                  state_in   = S_P2_SEL;
               end
            end else begin
               ram_raddr = slot(outer_set, i_ff);
               state_in  = S_OUT_LD;
            end
         end
         S_OUT_LD: begin
            fkey_in  = ram_rdata;
            j_in     = '0;
            state_in = S_FIND_RD;
         end
         S_P2_SEL: begin
            ram_raddr = slot(p2_set, i_ff);
            if (i_ff >= p2_n) begin
               if (is_union && !phase_b_ff) begin
                  phase_b_in = 1'b1;
                  i_in       = '0;
               end else begin
                  state_in = S_IDLE;
               end
            end else if (p2_need) begin
               state_in = S_P2_EMIT;
            end else begin
               i_in = i_inc;
            end
         end
         S_P2_EMIT: begin
            ram_raddr  = slot(p2_set, i_ff);
            emit_valid = 1'b1;
            emit_payload.status        = dsui_pkg::ST_OK;
            emit_payload.is_member     = 1'b0;
            emit_payload.set_size      = dsui_pkg::to_size(total_ff);
            emit_payload.element       = dsui_pkg::to_elem(ram_rdata);
            emit_payload.element_valid = 1'b1;
            emit_payload.last          = is_last;
            if (emit_ready) begin
               emitted_in = emitted_inc;
               i_in       = i_inc;
               state_in   = is_last ? S_IDLE : S_P2_SEL;
            end
         end
         S_EMIT1: begin
            emit_valid = 1'b1;
            if (emit_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (find_end) begin
         case (op_ff)
            dsui_pkg::OP_INSERT: begin
               state_in = S_EMIT1;
               size_in  = dsui_pkg::to_size(dsui_pkg::TOT_W'(cnt_cur));
               if (find_hit) begin
                  status_in = dsui_pkg::ST_DUPLICATE;
               end else if (cnt_cur >= dsui_pkg::CNT_W'(dsui_pkg::CAPACITY)) begin
                  status_in = dsui_pkg::ST_FULL;
               end else begin
                  ram_we    = 1'b1;
                  ram_waddr = slot(set_ff, cnt_cur);
                  ram_wdata = fkey_ff;
                  if (set_ff) begin
                     cnt_b_in = cnt_inc;
                  end else begin
                     cnt_a_in = cnt_inc;
                  end
                  status_in = dsui_pkg::ST_OK;
                  size_in   = dsui_pkg::to_size(dsui_pkg::TOT_W'(cnt_inc));
               end
            end
            dsui_pkg::OP_REMOVE: begin
               if (find_hit) begin
                  i_in     = j_ff;
                  state_in = S_SHIFT_RD;
               end else begin
                  status_in = dsui_pkg::ST_NOT_PRESENT;
                  size_in   = dsui_pkg::to_size(dsui_pkg::TOT_W'(cnt_cur));
                  state_in  = S_EMIT1;
               end
            end
            dsui_pkg::OP_QUERY: begin
               member_in = find_hit;
               status_in = dsui_pkg::ST_OK;
               size_in   = dsui_pkg::to_size(dsui_pkg::TOT_W'(cnt_cur));
               state_in  = S_EMIT1;
            end
            dsui_pkg::OP_UNION: begin
               flag_in[i_ff[dsui_pkg::IDX_W-1:0]] = !find_hit;
               hits_in  = hits_ff + dsui_pkg::CNT_W'(!find_hit);
               i_in     = i_inc;
               state_in = S_OUT_RD;
            end
            dsui_pkg::OP_INTER: begin
               flag_in[i_ff[dsui_pkg::IDX_W-1:0]] = find_hit;
               hits_in  = hits_ff + dsui_pkg::CNT_W'(find_hit);
               i_in     = i_inc;
               state_in = S_OUT_RD;
            end
            default: begin
               state_in = S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_a_ff <= '0;
         cnt_b_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_a_ff <= cnt_a_in;
         cnt_b_ff <= cnt_b_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      set_ff     <= set_in;
      fkey_ff    <= fkey_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      hits_ff    <= hits_in;
      flag_ff    <= flag_in;
      total_ff   <= total_in;
      emitted_ff <= emitted_in;
      phase_b_ff <= phase_b_in;
      status_ff  <= status_in;
      member_ff  <= member_in;
      size_ff    <= size_in;
   end

endmodule

// File: design/dsui_outreg.sv
// Output register that holds one result transfer while the consumer stalls.
module dsui_outreg (
   input  logic              clock,
   input  logic              reset,
   input  logic              emit_valid,
   output logic              emit_ready,
   input  dsui_pkg::rsp_type emit_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dsui_pkg::rsp_type rsp_payload
);

   logic              valid_ff, valid_in;
   dsui_pkg::rsp_type payload_ff, payload_in;

   assign emit_ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in   = valid_ff;
      payload_in = payload_ff;
      if (emit_valid && emit_ready) begin
         valid_in   = 1'b1;
         payload_in = emit_payload;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      payload_ff <= payload_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = payload_ff;

endmodule

// File: design/dual_set_union_intersection.sv
// Insert, query and remove scan the chosen set one key at a time, each key read and then compared;
// remove then moves every later key up one slot; clear and unused codes answer without a scan.
// Union and intersection run a flagging pass that searches the other set for each outer key,
// then scan the keys and emit each result. One item at a time.
// The single key RAM read port and the one key comparator serialise every scan.
// Reset clears both set counts and the sequencer; the key RAM is not cleared.
module dual_set_union_intersection (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dsui_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dsui_pkg::rsp_type rsp_payload
);

   logic                           emit_valid;
   logic                           emit_ready;
   dsui_pkg::rsp_type              emit_payload;
   logic                           ram_we;
   logic [dsui_pkg::ADDR_W-1:0]    ram_waddr;
   logic [dsui_pkg::KEY_WIDTH-1:0] ram_wdata;
   logic [dsui_pkg::ADDR_W-1:0]    ram_raddr;
   logic [dsui_pkg::KEY_WIDTH-1:0] ram_rdata;

   dsui_ram #(
      .WIDTH (dsui_pkg::KEY_WIDTH),
      .DEPTH (dsui_pkg::DEPTH)
   ) u_key_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   dsui_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .emit_valid   (emit_valid),
      .emit_ready   (emit_ready),
      .emit_payload (emit_payload),
      .ram_we       (ram_we),
      .ram_waddr    (ram_waddr),
      .ram_wdata    (ram_wdata),
      .ram_raddr    (ram_raddr),
      .ram_rdata    (ram_rdata)
   );

   dsui_outreg u_outreg (
      .clock        (clock),
      .reset        (reset),
      .emit_valid   (emit_valid),
      .emit_ready   (emit_ready),
      .emit_payload (emit_payload),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload)
   );

endmodule

// File: design/dsui_checker.sv
// Port-level assertions for the set block and the bind that attaches them.
`include "dual_set_union_intersection_macros.svh"

module dsui_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input dsui_pkg::rsp_type rsp_payload
);

   `DSUI_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload), "stalled result transfer changed")
   `DSUI_ASSERT_NXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall, "block took a second request without working the first")
   `DSUI_ASSERT_IMP(a_empty_item, clock, reset, rsp_valid && !rsp_payload.element_valid, (rsp_payload.element == '0) && rsp_payload.last, "item without element is not a zero final item")
   `DSUI_ASSERT_IMP(a_elem_item, clock, reset, rsp_valid && rsp_payload.element_valid, (rsp_payload.status == dsui_pkg::ST_OK) && !rsp_payload.is_member, "set result item carries status or membership")
   `DSUI_ASSERT_NXT_ALWAYS(a_reset_idle, clock, reset, !rsp_valid, "result valid right after reset")

endmodule

bind dual_set_union_intersection dsui_checker u_checker (.*);
